FILE: hdl/assert_macros.svh
// Assertion macros used by the interpolator back end.
// Needs a clock named clk and a synchronous reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define QGI_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define QGI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/qgi_pkg.sv
// Shared types and constants of the quadrilinear grid interpolator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qgi_pkg;
  localparam int WORD_W    = 32;
  localparam int ADDR_W    = 16;
  localparam int IDX_W     = 8;   // x and y index, up to 256 points
  localparam int EIDX_W    = 6;   // energy and time index, up to 64 points
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COORD_MIN, REG_ENERGY_MIN, REG_INV_XY, REG_INV_E,
    REG_INV_T, REG_POINTS_XY, REG_ENERGY_LEVELS, REG_TIME_STEPS
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] coord_min;
    logic [WORD_W-1:0] energy_min;
    logic [WORD_W-1:0] inv_xy;
    logic [WORD_W-1:0] inv_e;
    logic [WORD_W-1:0] inv_t;
    logic [5:0]        points_xy;
    logic [3:0]        energy_levels;
    logic [3:0]        time_steps;
  } cfg_t;

  typedef struct packed {
    logic              is_query;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wval;
    logic [IDX_W-1:0]  xl, xh, yl, yh;
    logic [EIDX_W-1:0] el, eh, tl, th;
    logic [FRAC_W-1:0] fx, fy, fe, ft;
    logic              flag;
  } cmd_t;
endpackage
`default_nettype wire

FILE: hdl/quadrilinear_grid_interpolator.sv
// Quadrilinear grid interpolator. A write item (kind 0) stores one signed Q16.16
// word at write_addr, laid out as ((t*MAX_XY_POINTS + x)*MAX_XY_POINTS + y)
// *MAX_ENERGY_LEVELS + e; it gives no result. A query item (kind 1) gives one
// result: each coordinate is mapped to a grid index and 16-bit fraction, sixteen
// corners are read and blended along t, e, y, then x with round-half-up. Clamped
// coordinates set out_of_range. Grid words read before being written are undefined.
// Steps: the front end takes a query through an accept state, a 32x32 multiply and
// a classify state per axis, and a hand-off state; a write only accepts and hands off.
// The back end stores a write in its idle state; a query is popped, its sixteen corners
// are read through the single-ported grid memory, and 15 blends of a multiply and an add
// state each run through one shared blend multiplier, the last held while output stalls.
// A two-entry queue lets the front end map the next query while the back end works.
`timescale 1ns / 1ps
`default_nettype none
module quadrilinear_grid_interpolator #(
  parameter int MAX_XY_POINTS     = 32,
  parameter int MAX_ENERGY_LEVELS = 8,
  parameter int MAX_TIME_STEPS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [31:0] coord_x,
  input  wire logic [31:0] coord_y,
  input  wire logic [31:0] energy,
  input  wire logic [31:0] query_time,
  input  wire logic [15:0] write_addr,
  input  wire logic [31:0] write_value,
  // Output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      interp_value,
  output logic             out_of_range
);
  import qgi_pkg::*;

  cfg_t cfg;
  logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  cmd_t q_push_data, q_pop_data;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coord_min     <= 32'd0;
      cfg.energy_min    <= 32'd0;
      cfg.inv_xy        <= 32'd65536;
      cfg.inv_e         <= 32'd65536;
      cfg.inv_t         <= 32'd65536;
      cfg.points_xy     <= 6'd32;
      cfg.energy_levels <= 4'd8;
      cfg.time_steps    <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COORD_MIN:     cfg.coord_min     <= cfg_data;
        REG_ENERGY_MIN:    cfg.energy_min    <= cfg_data;
        REG_INV_XY:        cfg.inv_xy        <= cfg_data;
        REG_INV_E:         cfg.inv_e         <= cfg_data;
        REG_INV_T:         cfg.inv_t         <= cfg_data;
        REG_POINTS_XY:     cfg.points_xy     <= cfg_data[5:0];
        REG_ENERGY_LEVELS: cfg.energy_levels <= cfg_data[3:0];
        REG_TIME_STEPS:    cfg.time_steps    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Front end: accept and map coordinates.
  qgi_front #(
    .MAX_XY_POINTS(MAX_XY_POINTS),
    .MAX_ENERGY_LEVELS(MAX_ENERGY_LEVELS),
    .MAX_TIME_STEPS(MAX_TIME_STEPS)
  ) u_front (
    .clk, .rst, .in_valid, .in_ready, .kind, .coord_x, .coord_y, .energy,
    .query_time, .write_addr, .write_value, .cfg,
    .push_valid(q_push_valid), .push_ready(q_push_ready), .push_data(q_push_data)
  );

  // Decouple front and back.
  qgi_queue u_queue (
    .clk, .rst,
    .push_valid(q_push_valid), .push_ready(q_push_ready), .push_data(q_push_data),
    .pop_valid(q_pop_valid), .pop_ready(q_pop_ready), .pop_data(q_pop_data)
  );

  // Back end: memory access and blending.
  qgi_back #(
    .MAX_XY_POINTS(MAX_XY_POINTS),
    .MAX_ENERGY_LEVELS(MAX_ENERGY_LEVELS)
  ) u_back (
    .clk, .rst,
    .pop_valid(q_pop_valid), .pop_ready(q_pop_ready), .pop_data(q_pop_data),
    .out_valid, .out_ready, .interp_value, .out_of_range
  );
endmodule
`default_nettype wire

FILE: hdl/qgi_front.sv
// Front end: accepts items, maps query coordinates onto grid indices and fractions.
// Depends on qgi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qgi_front #(
  parameter int MAX_XY_POINTS     = 32,
  parameter int MAX_ENERGY_LEVELS = 8,
  parameter int MAX_TIME_STEPS    = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      kind,
  input  wire logic [31:0]               coord_x,
  input  wire logic [31:0]               coord_y,
  input  wire logic [31:0]               energy,
  input  wire logic [31:0]               query_time,
  input  wire logic [15:0]               write_addr,
  input  wire logic [31:0]               write_value,
  input  wire qgi_pkg::cfg_t             cfg,
  output logic                           push_valid,
  input  wire logic                      push_ready,
  output qgi_pkg::cmd_t                  push_data
);
  import qgi_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001, F_MUL = 4'b0010, F_CLS = 4'b0100, F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state;
  logic [1:0]  ax;
  logic [31:0] cx, cy, ce, ct;
  logic        neg;
  logic [63:0] prod;
  cmd_t        cmd;

  logic [8:0]  nxy, ne, nt, nsel;
  logic [32:0] diff;
  logic [31:0] inv;
  logic [31:0] idx, nm1;
  logic [15:0] frac;
  logic [7:0]  lo, hi;
  logic        clamp;

  // Saturate the point counts to 2..MAX.
  always_comb begin
    nxy = (cfg.points_xy < 6'd2) ? 9'd2 :
          ((9'(cfg.points_xy) > 9'(MAX_XY_POINTS)) ? 9'(MAX_XY_POINTS) : 9'(cfg.points_xy));
    ne  = (cfg.energy_levels < 4'd2) ? 9'd2 :
          ((9'(cfg.energy_levels) > 9'(MAX_ENERGY_LEVELS)) ?
           9'(MAX_ENERGY_LEVELS) : 9'(cfg.energy_levels));
    nt  = (cfg.time_steps < 4'd2) ? 9'd2 :
          ((9'(cfg.time_steps) > 9'(MAX_TIME_STEPS)) ?
           9'(MAX_TIME_STEPS) : 9'(cfg.time_steps));
  end

  always_comb begin
    case (ax)
      2'd0: begin
        diff = {cx[31], cx} - {cfg.coord_min[31], cfg.coord_min};
        inv = cfg.inv_xy; nsel = nxy;
      end
      2'd1: begin
        diff = {cy[31], cy} - {cfg.coord_min[31], cfg.coord_min};
        inv = cfg.inv_xy; nsel = nxy;
      end
      2'd2: begin
        diff = {ce[31], ce} - {cfg.energy_min[31], cfg.energy_min};
        inv = cfg.inv_e; nsel = ne;
      end
      default: begin
        diff = {ct[31], ct};
        inv = cfg.inv_t; nsel = nt;
      end
    endcase
  end

  // Classify the registered product: clamp below and above the grid.
  always_comb begin
    nm1   = 32'(nsel) - 32'd1;
    idx   = prod[63:32];
    frac  = prod[31:16];
    clamp = 1'b0;
    if (neg) begin
      idx = 32'd0; frac = 16'd0; clamp = 1'b1;
    end else if (idx > nm1 || (idx == nm1 && frac != 16'd0)) begin
      idx = nm1; frac = 16'd0; clamp = 1'b1;
    end
    lo = idx[7:0];
    hi = (idx == nm1) ? lo : lo + 8'd1;
  end

  assign in_ready   = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_data  = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      ax    <= 2'd0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            cx <= coord_x; cy <= coord_y; ce <= energy; ct <= query_time;
            cmd.is_query <= kind;
            cmd.waddr    <= write_addr;
            cmd.wval     <= write_value;
            cmd.flag     <= 1'b0;
            ax           <= 2'd0;
            state        <= kind ? F_MUL : F_PUSH;
          end
        end
        F_MUL: begin
          neg   <= diff[32];
          prod  <= 64'(diff[31:0]) * 64'(inv);
          state <= F_CLS;
        end
        F_CLS: begin
          if (clamp) cmd.flag <= 1'b1;
          case (ax)
            2'd0: begin cmd.xl <= lo; cmd.xh <= hi; cmd.fx <= frac; end
            2'd1: begin cmd.yl <= lo; cmd.yh <= hi; cmd.fy <= frac; end
            2'd2: begin
              cmd.el <= lo[EIDX_W-1:0]; cmd.eh <= hi[EIDX_W-1:0]; cmd.fe <= frac;
            end
            default: begin
              cmd.tl <= lo[EIDX_W-1:0]; cmd.th <= hi[EIDX_W-1:0]; cmd.ft <= frac;
            end
          endcase
          ax    <= ax + 2'd1;
          state <= (ax == 2'd3) ? F_PUSH : F_MUL;
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/qgi_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on qgi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qgi_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire qgi_pkg::cmd_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output qgi_pkg::cmd_t      pop_data
);
  import qgi_pkg::*;

  cmd_t       mem [0:1];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_data;
    if (rst) begin
      wptr <= 1'b0; rptr <= 1'b0; count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/qgi_back.sv
// Back end: grid memory, corner reads and the shared blend unit.
// Depends on qgi_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
module qgi_back #(
  parameter int MAX_XY_POINTS     = 32,
  parameter int MAX_ENERGY_LEVELS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pop_valid,
  output logic               pop_ready,
  input  wire qgi_pkg::cmd_t pop_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        interp_value,
  output logic               out_of_range
);
  import qgi_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001, B_READ = 4'b0010, B_MUL = 4'b0100, B_ADD = 4'b1000
  } bstate_t;

  bstate_t     state;
  cmd_t        cmd;
  logic [31:0] gmem [0:65535];
  logic [31:0] rdata;
  logic [15:0] maddr;
  logic        mwe;
  logic [4:0]  rd_cnt;
  logic [4:0]  vcnt;
  logic [3:0]  step;
  logic [31:0] sh [0:15];
  logic [31:0] a_r;
  logic signed [49:0] prod_r;
  logic        fire;

  logic [7:0]  cx, cy;
  logic [5:0]  ce, ct;
  logic [31:0] lin;
  logic [15:0] fsel;
  logic signed [32:0] d;
  logic signed [49:0] rnd;
  logic [31:0] res;

  // Corner order: t fastest, then e, y, x; adjacent pairs blend in order.
  always_comb begin
    cx  = rd_cnt[3] ? cmd.xh : cmd.xl;
    cy  = rd_cnt[2] ? cmd.yh : cmd.yl;
    ce  = rd_cnt[1] ? cmd.eh : cmd.el;
    ct  = rd_cnt[0] ? cmd.th : cmd.tl;
    lin = ((32'(ct) * 32'(MAX_XY_POINTS) + 32'(cx)) * 32'(MAX_XY_POINTS) + 32'(cy))
          * 32'(MAX_ENERGY_LEVELS) + 32'(ce);
  end

  assign pop_ready = (state == B_IDLE);
  assign mwe       = (state == B_IDLE) && pop_valid && !pop_data.is_query;
  assign maddr     = (state == B_IDLE) ? pop_data.waddr : lin[15:0];
  assign fire      = (state == B_ADD) && (step == 4'd14) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (mwe) gmem[maddr] <= pop_data.wval;
    rdata <= gmem[maddr];
  end

  always_comb begin
    if (step < 4'd8)       fsel = cmd.ft;
    else if (step < 4'd12) fsel = cmd.fe;
    else if (step < 4'd14) fsel = cmd.fy;
    else                   fsel = cmd.fx;
    d   = $signed({sh[1][31], sh[1]}) - $signed({sh[0][31], sh[0]});
    rnd = (prod_r + 50'sd32768) >>> 16;
    res = a_r + rnd[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      rd_cnt    <= 5'd0;
      vcnt      <= 5'd0;
      step      <= 4'd0;
    end else begin
      if (fire)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (pop_valid && pop_data.is_query) begin
            cmd    <= pop_data;
            rd_cnt <= 5'd0;
            state  <= B_READ;
          end
        end
        B_READ: begin
          if (rd_cnt != 5'd0) begin
            for (int i = 0; i < 15; i++) sh[i] <= sh[i+1];
            sh[15] <= rdata;
          end
          if (rd_cnt == 5'd16) begin
            vcnt  <= 5'd16;
            step  <= 4'd0;
            state <= B_MUL;
          end else begin
            rd_cnt <= rd_cnt + 5'd1;
          end
        end
        B_MUL: begin
          a_r    <= sh[0];
          prod_r <= 50'(d * $signed({1'b0, fsel}));
          for (int i = 0; i < 14; i++) sh[i] <= sh[i+2];
          vcnt   <= vcnt - 5'd2;
          state  <= B_ADD;
        end
        B_ADD: begin
          if (step == 4'd14) begin
            // Hold the final blend until the output register frees up.
            if (fire) begin
              interp_value <= res;
              out_of_range <= cmd.flag;
              state        <= B_IDLE;
            end
          end else begin
            sh[vcnt[3:0]] <= res;
            vcnt  <= vcnt + 5'd1;
            step  <= step + 4'd1;
            state <= B_MUL;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `QGI_ASSERT_ALWAYS(a_stack_depth, (state != B_ADD) || (vcnt == 5'd14 - 5'(step)))
  `QGI_ASSERT_ALWAYS(a_write_idle, !mwe || (state == B_IDLE))
  `QGI_ASSERT_NEXT(a_read_done, (state == B_READ) && (rd_cnt == 5'd16), state == B_MUL)
endmodule
`default_nettype wire

FILE: tb/sv/qgi_checker.sv
// Checker for the quadrilinear grid interpolator: watches both item channels
// and the register port, predicts every query result and compares it.
// Depends on qgi_pkg for the register index names.
`timescale 1ns / 1ps
`default_nettype none
module qgi_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        kind,
  input  wire logic [31:0] coord_x,
  input  wire logic [31:0] coord_y,
  input  wire logic [31:0] energy,
  input  wire logic [31:0] query_time,
  input  wire logic [15:0] write_addr,
  input  wire logic [31:0] write_value,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] interp_value,
  input  wire logic        out_of_range,
  output int               fail_count,
  output int               pending
);
  import qgi_pkg::*;

  localparam int XY_MAX = 32;
  localparam int E_MAX  = 8;
  localparam int T_MAX  = 8;

  typedef struct {
    logic [31:0] value;
    logic        clamped;
  } interp_t;

  logic [31:0] grid_copy [0:65535];
  logic [31:0] min_xy, min_e, inv_xy, inv_e, inv_t;
  logic [5:0]  n_xy;
  logic [3:0]  n_e, n_t;
  interp_t     interp_q[$];

  function automatic int clamp_count(input int n, input int maxn);
    if (n < 2) return 2;
    if (n > maxn) return maxn;
    return n;
  endfunction

  // Position on one axis: grid index pair, fraction and clamp flag.
  function automatic void locate(input longint diff, input logic [31:0] inv, input int n,
                                 output int lo, output int hi, output longint frac,
                                 inout bit flag);
    longint unsigned prod;
    longint unsigned idx;
    longint unsigned f;
    if (diff < 0) begin
      idx = 0;
      f = 0;
      flag = 1;
    end else begin
      prod = longint'(diff) * longint'({32'b0, inv});
      idx = prod >> 32;
      f = (prod >> 16) & 64'hFFFF;
      if (idx > n - 1 || (idx == n - 1 && f != 0)) begin
        idx = n - 1;
        f = 0;
        flag = 1;
      end
    end
    lo = int'(idx);
    hi = (lo == n - 1) ? lo : lo + 1;
    frac = longint'(f);
  endfunction

  function automatic longint lerp(input longint a, input longint b, input longint f);
    longint s;
    s = a * (65536 - f) + b * f + 32768;
    return s >>> 16;
  endfunction

  function automatic longint word_at(input int t, input int x, input int y, input int e);
    int a;
    a = ((t * XY_MAX + x) * XY_MAX + y) * E_MAX + e;
    return longint'($signed(grid_copy[a & 16'hFFFF]));
  endfunction

  function automatic interp_t predict_query();
    interp_t r;
    bit flag;
    int nxy, ne, nt, x, y, e, i;
    int xs [2], ys [2], es [2], ts [2];
    longint fx, fy, fe, ft;
    longint c [8];
    longint v00, v01, v10, v11, w0, w1;
    flag = 0;
    nxy = clamp_count(n_xy, XY_MAX);
    ne = clamp_count(n_e, E_MAX);
    nt = clamp_count(n_t, T_MAX);
    locate(longint'($signed(coord_x)) - longint'($signed(min_xy)), inv_xy, nxy,
           xs[0], xs[1], fx, flag);
    locate(longint'($signed(coord_y)) - longint'($signed(min_xy)), inv_xy, nxy,
           ys[0], ys[1], fy, flag);
    locate(longint'($signed(energy)) - longint'($signed(min_e)), inv_e, ne,
           es[0], es[1], fe, flag);
    locate(longint'($signed(query_time)), inv_t, nt, ts[0], ts[1], ft, flag);
    // blend along t first; corner i = {x, y, e} bits
    for (i = 0; i < 8; i++) begin
      x = xs[i[2]];
      y = ys[i[1]];
      e = es[i[0]];
      c[i] = lerp(word_at(ts[0], x, y, e), word_at(ts[1], x, y, e), ft);
    end
    v00 = lerp(c[0], c[1], fe);
    v01 = lerp(c[2], c[3], fe);
    v10 = lerp(c[4], c[5], fe);
    v11 = lerp(c[6], c[7], fe);
    w0 = lerp(v00, v01, fy);
    w1 = lerp(v10, v11, fy);
    r.value = 32'(lerp(w0, w1, fx));
    r.clamped = flag;
    return r;
  endfunction

  assign pending = interp_q.size();

  always @(posedge clk) begin
    interp_t got;
    interp_t want;
    if (rst) begin
      min_xy <= 32'd0;
      min_e <= 32'd0;
      inv_xy <= 32'h10000;
      inv_e <= 32'h10000;
      inv_t <= 32'h10000;
      n_xy <= 6'd32;
      n_e <= 4'd8;
      n_t <= 4'd8;
      interp_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_COORD_MIN:     min_xy <= cfg_data;
          REG_ENERGY_MIN:    min_e <= cfg_data;
          REG_INV_XY:        inv_xy <= cfg_data;
          REG_INV_E:         inv_e <= cfg_data;
          REG_INV_T:         inv_t <= cfg_data;
          REG_POINTS_XY:     n_xy <= cfg_data[5:0];
          REG_ENERGY_LEVELS: n_e <= cfg_data[3:0];
          REG_TIME_STEPS:    n_t <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (kind) interp_q.insert(interp_q.size(), predict_query());
        else grid_copy[write_addr] = write_value;
      end
      if (out_valid && out_ready) begin
        got.value = interp_value;
        got.clamped = out_of_range;
        if (interp_q.size() == 0) begin
          $display("%0t: unexpected result value=%h flag=%b", $time, got.value,
                   got.clamped);
          fail_count <= fail_count + 1;
        end else begin
          want = interp_q.pop_front();
          if (got.value !== want.value || got.clamped !== want.clamped) begin
            $display("%0t: mismatch expected value=%h flag=%b actual value=%h flag=%b",
                     $time, want.value, want.clamped, got.value, got.clamped);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: tb/sv/tb_quadrilinear_grid_interpolator.sv
// Testbench top for the quadrilinear grid interpolator: makes stimulus, idles
// both channels and gives the verdict. Depends on qgi_pkg, qgi_checker and quadrilinear_grid_interpolator.
`timescale 1ns / 1ps
`default_nettype none
module tb_quadrilinear_grid_interpolator;
  import qgi_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int XY_MAX = 32;
  localparam int E_MAX  = 8;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        kind = 0;
  logic [31:0] coord_x = 0, coord_y = 0, energy = 0, query_time = 0;
  logic [15:0] write_addr = 0;
  logic [31:0] write_value = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] interp_value;
  logic        out_of_range;
  int          fail_count, pending;

  // Stimulus-side copy of the grid setup, used to aim queries onto the grid.
  logic [31:0] set_min_xy, set_min_e, set_inv_xy, set_inv_e, set_inv_t;
  int          set_n_xy, set_n_e, set_n_t;
  bit          calm = 0;          // no idling on either side
  bit          squeeze_req = 0;   // ask the receiver for one long hold-off
  int          stall_left = 0;
  bit          seen [0:65535];    // grid words written so far

  always #2 clk = ~clk;

  quadrilinear_grid_interpolator u_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .kind, .coord_x, .coord_y, .energy, .query_time,
    .write_addr, .write_value,
    .out_valid, .out_ready, .interp_value, .out_of_range
  );

  qgi_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .kind, .coord_x, .coord_y, .energy, .query_time,
    .write_addr, .write_value,
    .out_valid, .out_ready, .interp_value, .out_of_range,
    .fail_count, .pending
  );

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        squeeze_req = 0;
        stall_left = 400;
      end
      if (rst) begin
        out_ready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic int clamp_count(input int n, input int maxn);
    if (n < 2) return 2;
    if (n > maxn) return maxn;
    return n;
  endfunction

  // Grid index pair that a query reads on one axis.
  function automatic void axis_span(input longint diff, input logic [31:0] inv, input int n,
                                    output int lo, output int hi);
    longint unsigned prod;
    longint unsigned idx;
    if (diff < 0) begin
      idx = 0;
    end else begin
      prod = longint'(diff) * longint'({32'b0, inv});
      idx = prod >> 32;
      if (idx > n - 1) idx = n - 1;
    end
    lo = int'(idx);
    hi = (lo == n - 1) ? lo : lo + 1;
  endfunction

  // Hold the item until accepted; return at the falling edge after acceptance.
  task automatic push_item(input logic k, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] e, input logic [31:0] t,
                           input logic [15:0] a, input logic [31:0] v);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1;
    kind <= k;
    coord_x <= x;
    coord_y <= y;
    energy <= e;
    query_time <= t;
    write_addr <= a;
    write_value <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic store_word(input logic [15:0] a, input logic [31:0] v);
    seen[a] = 1;
    push_item(1'b0, $urandom, $urandom, $urandom, $urandom, a, v);
  endtask

  // Write any corner word the query would read that was never written, then query.
  task automatic ask(input logic [31:0] x, input logic [31:0] y, input logic [31:0] e,
                     input logic [31:0] t);
    int xs [2], ys [2], es [2], ts [2];
    int k;
    logic [15:0] a;
    axis_span(longint'($signed(x)) - longint'($signed(set_min_xy)), set_inv_xy, set_n_xy,
              xs[0], xs[1]);
    axis_span(longint'($signed(y)) - longint'($signed(set_min_xy)), set_inv_xy, set_n_xy,
              ys[0], ys[1]);
    axis_span(longint'($signed(e)) - longint'($signed(set_min_e)), set_inv_e, set_n_e,
              es[0], es[1]);
    axis_span(longint'($signed(t)), set_inv_t, set_n_t, ts[0], ts[1]);
    for (k = 0; k < 16; k++) begin
      a = 16'(((ts[k[0]] * XY_MAX + xs[k[3]]) * XY_MAX + ys[k[2]]) * E_MAX + es[k[1]]);
      if (!seen[a]) store_word(a, $urandom);
    end
    push_item(1'b1, x, y, e, t, $urandom, $urandom);
  endtask

  // Write every register, then drop the enable once.
  task automatic setup_grid(input logic [31:0] mxy, input logic [31:0] me,
                            input logic [31:0] ixy, input logic [31:0] ie,
                            input logic [31:0] it, input logic [31:0] nxy,
                            input logic [31:0] ne, input logic [31:0] nt);
    logic [31:0] vals [8];
    int i;
    vals = '{mxy, me, ixy, ie, it, nxy, ne, nt};
    for (i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 0;
    set_min_xy = mxy;
    set_min_e = me;
    set_inv_xy = ixy;
    set_inv_e = ie;
    set_inv_t = it;
    set_n_xy = clamp_count(nxy[5:0], 32);
    set_n_e = clamp_count(ne[3:0], 8);
    set_n_t = clamp_count(nt[3:0], 8);
  endtask

  // Coordinate on an axis: mostly on or just past the grid, sometimes anywhere.
  function automatic logic [31:0] aim(input logic [31:0] lo, input logic [31:0] inv,
                                      input int n);
    longint p, c;
    if ($urandom_range(0, 4) == 0) return $urandom;
    p = $urandom_range(0, n * 65536);
    if ($urandom_range(0, 3) == 0) p = (p >> 16) << 16;   // exact grid point
    if (inv == 0) c = longint'($signed(lo)) + p;
    else c = longint'($signed(lo)) + (p << 16) / longint'({32'b0, inv});
    return c[31:0];
  endfunction

  task automatic random_query();
    ask(aim(set_min_xy, set_inv_xy, set_n_xy), aim(set_min_xy, set_inv_xy, set_n_xy),
        aim(set_min_e, set_inv_e, set_n_e), aim(32'h0, set_inv_t, set_n_t));
  endtask

  // Let the block settle: drop valid, all results in, then trailing writes retired.
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int i, ph;
    logic [31:0] wmax, wmin;
    wmax = 32'h7FFF_FFFF;
    wmin = 32'h8000_0000;
    repeat (6) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    setup_grid(0, 0, 32'h10000, 32'h10000, 32'h10000, 32, 8, 8);

    // Directed: store extremes, then grid corners, edges and far-off points.
    store_word(16'h0000, wmax);
    store_word(16'hFFFF, wmin);
    store_word(16'h0001, wmin);
    ask(0, 0, 0, 0);
    ask(32'h001F_0000, 32'h001F_0000, 32'h0007_0000, 32'h0007_0000);
    ask(32'h001F_0001, 32'h0000_8000, 32'h0003_C000, 32'h0006_FFFF);
    ask(wmin, wmin, wmin, wmin);
    ask(wmax, wmax, wmax, wmax);
    ask(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_FFFF, 32'hFFFF_0000);
    ask(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    drain();

    // Extreme settings: count registers below 2, zero inverse spacing.
    setup_grid(wmin, wmax, 0, 0, 0, 0, 0, 0);
    ask(wmin, wmin, wmax, 0);
    ask(wmax, 0, wmin, wmax);
    ask(0, 32'h0001_0000, wmax, 32'h0000_8000);
    drain();
    // Counts above their maxima, largest inverse spacing.
    setup_grid(32'hFFFF_0000, wmin, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    ask(32'hFFFF_0000, 32'hFFFF_0001, wmin, 0);
    ask(32'hFFFF_0000, 32'hFFFF_0000, 32'h8000_0001, 32'h0000_0001);
    ask(32'hFFFF_0000, wmax, 32'h8000_0000, wmin);
    drain();

    // Random phases on small grids; the last one runs without idling.
    for (ph = 0; ph < 8; ph++) begin
      if (ph == 7) calm = 1;
      setup_grid($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h40000) - 32'h20000,
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h40000) - 32'h20000,
                 $urandom_range(32'h4000, 32'h40000), $urandom_range(32'h4000, 32'h40000),
                 $urandom_range(32'h4000, 32'h40000),
                 $urandom_range(0, 7), $urandom_range(0, 4), $urandom_range(0, 3));
      // One long hold-off while queries keep coming: fill the block up.
      if (ph == 2) squeeze_req = 1;
      for (i = 0; i < 70; i++) begin
        if ($urandom_range(0, 4) == 0) store_word($urandom, $urandom);
        else random_query();
      end
      drain();
    end

    // Give the verdict.
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
+incdir+hdl
hdl/qgi_pkg.sv
hdl/qgi_front.sv
hdl/qgi_queue.sv
hdl/qgi_back.sv
hdl/quadrilinear_grid_interpolator.sv
tb/sv/qgi_checker.sv
tb/sv/tb_quadrilinear_grid_interpolator.sv
